// ===== hdl/fpec_pkg.sv =====
// Shared types and constants of the flash program and erase controller.
package fpec_pkg;

	// Input and output field widths.
	localparam int ACTION_W = 3;
	localparam int SEL_W    = 2;
	localparam int WADDR_W  = 9;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int ETICK_W  = 16;
	localparam int PTICK_W  = 8;
	localparam int SNB_W    = 4;
	localparam int PSIZE_W  = 2;

	// Number of words the word address can reach.
	localparam int ADDR_SPACE = 512;

	// Bus actions.
	localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_REG_WR = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_REG_RD = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_ARR_WR = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_ARR_RD = 3'd4;

	// Register selectors.
	localparam logic [SEL_W-1:0] SEL_KEY    = 2'd0;
	localparam logic [SEL_W-1:0] SEL_STATUS = 2'd1;
	localparam logic [SEL_W-1:0] SEL_CTRL   = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LOCKED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADKEY   = 3'd4;

	// Unlock key words.
	localparam logic [DATA_W-1:0] KEY_FIRST  = 32'h4567_0123;
	localparam logic [DATA_W-1:0] KEY_SECOND = 32'hCDEF_89AB;

	// Control and status register bit positions.
	localparam int CR_PG        = 0;
	localparam int CR_SER       = 1;
	localparam int CR_SNB_LSB   = 3;
	localparam int CR_PSIZE_LSB = 8;
	localparam int CR_STRT      = 16;
	localparam int CR_LOCK      = 31;
	localparam int SR_BSY       = 16;

	// Register configuration indexes.
	localparam logic CFG_ERASE_TICKS   = 1'b0;
	localparam logic CFG_PROGRAM_TICKS = 1'b1;

	// How an item finishes once decoded.
	typedef enum logic [1:0] {
		K_SIMPLE,
		K_READ,
		K_PROG,
		K_ERASE
	} op_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic fin;
		logic sweep;
	} fpec_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_kind_t kind;
		logic     sweep_last;
	} fpec_stat_t;

endpackage

// ===== hdl/flash_program_erase_controller.sv =====
// Register accesses, ticks and rejected items give the strobe from the execute state.
// Array reads and word programs add a finish state (one registered read of the array port).
// A sector erase passes the execute and sweep states, writing one word of the sector a cycle.
// The next start is taken in the cycle that carries the done strobe.
// Reset: control relocks; the array is swept to all ones, one word a cycle, with busy high,
// over min(NUM_SECTORS*WORDS_PER_SECTOR, 512) implemented words; results are never stalled.
module flash_program_erase_controller #(
	parameter int NUM_SECTORS      = 8,
	parameter int WORDS_PER_SECTOR = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	output logic                            done,
	input  logic [fpec_pkg::ACTION_W-1:0]   action,
	input  logic [fpec_pkg::SEL_W-1:0]      reg_select,
	input  logic [fpec_pkg::WADDR_W-1:0]    word_address,
	input  logic [fpec_pkg::DATA_W-1:0]     write_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [fpec_pkg::ETICK_W-1:0]    cfg_data,
	output logic [fpec_pkg::DATA_W-1:0]     read_data,
	output logic                            busy_res,
	output logic                            locked,
	output logic [fpec_pkg::STATUS_W-1:0]   status
);
	import fpec_pkg::*;

	fpec_cmd_t  cmd;
	fpec_stat_t stat;

	// Sequencer.
	fpec_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Registers, array and erase sweep.
	fpec_dp #(
		.NUM_SECTORS      (NUM_SECTORS),
		.WORDS_PER_SECTOR (WORDS_PER_SECTOR)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.reg_select   (reg_select),
		.word_address (word_address),
		.write_data   (write_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.read_data    (read_data),
		.busy_res     (busy_res),
		.locked       (locked),
		.status       (status)
	);

endmodule

// ===== hdl/fpec_ctrl.sv =====
// Sequencing state machine of the flash program and erase controller.
module fpec_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fpec_pkg::fpec_stat_t stat,
	output fpec_pkg::fpec_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import fpec_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_FIN,
		S_SWEEP
	} state_t;

	state_t state_q;
	logic   done_q;

	// Commands follow the current state.
	assign cmd.load  = (state_q == S_IDLE) && start;
	assign cmd.exec  = (state_q == S_EXEC);
	assign cmd.fin   = (state_q == S_FIN);
	assign cmd.sweep = (state_q == S_SWEEP) || (state_q == S_CLEAR);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// State and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					done_q <= 1'b0;
					if (stat.sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (stat.kind)
						K_SIMPLE: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						K_READ, K_PROG: begin
							done_q  <= 1'b0;
							state_q <= S_FIN;
						end
						K_ERASE: begin
							done_q  <= 1'b0;
							state_q <= S_SWEEP;
						end
					endcase
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					done_q <= stat.sweep_last;
					if (stat.sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/fpec_dp.sv =====
// Datapath of the flash program and erase controller: registers, array and erase sweep.
module fpec_dp #(
	parameter int NUM_SECTORS      = 8,
	parameter int WORDS_PER_SECTOR = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fpec_pkg::fpec_cmd_t             cmd,
	output fpec_pkg::fpec_stat_t            stat,
	input  logic [fpec_pkg::ACTION_W-1:0]   action,
	input  logic [fpec_pkg::SEL_W-1:0]      reg_select,
	input  logic [fpec_pkg::WADDR_W-1:0]    word_address,
	input  logic [fpec_pkg::DATA_W-1:0]     write_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [fpec_pkg::ETICK_W-1:0]    cfg_data,
	output logic [fpec_pkg::DATA_W-1:0]     read_data,
	output logic                            busy_res,
	output logic                            locked,
	output logic [fpec_pkg::STATUS_W-1:0]   status
);
	import fpec_pkg::*;

	localparam int ARRAY_WORDS = NUM_SECTORS * WORDS_PER_SECTOR;
	localparam int MEM_WORDS   = (ARRAY_WORDS < ADDR_SPACE) ? ARRAY_WORDS : ADDR_SPACE;
	localparam int MAW         = $clog2(MEM_WORDS);
	localparam int FW          = $clog2(ARRAY_WORDS + 1);
	localparam logic [FW-1:0]      WPS_F   = FW'(WORDS_PER_SECTOR);
	localparam logic [FW-1:0]      MEM_F   = FW'(MEM_WORDS);
	localparam logic [WADDR_W:0]   MEM_A   = (WADDR_W + 1)'(MEM_WORDS);
	localparam logic [SNB_W:0]     NSEC_F  = (SNB_W + 1)'(NUM_SECTORS);

	// Latched input item.
	logic [ACTION_W-1:0] act_q;
	logic [SEL_W-1:0]    sel_q;
	logic [WADDR_W-1:0]  addr_q;
	logic [DATA_W-1:0]   data_q;

	// Architectural state.
	logic               lock_q, key_q, pg_q, ser_q;
	logic [SNB_W-1:0]   snb_q;
	logic [PSIZE_W-1:0] psize_q;
	logic [ETICK_W-1:0] bcnt_q;
	logic [ETICK_W-1:0] erase_ticks_q;
	logic [PTICK_W-1:0] prog_ticks_q;

	// Results and operation bookkeeping.
	logic [DATA_W-1:0]   rd_q;
	logic [STATUS_W-1:0] st_q;
	op_kind_t            kind_q;

	// Sweep engine and array.
	logic [FW-1:0]     sweep_addr_q, sweep_end_q;
	logic [DATA_W-1:0] mem [MEM_WORDS];
	logic [DATA_W-1:0] rdata_q;

	// Next-state values decoded in the execute cycle.
	logic               n_lock, n_key, n_pg, n_ser;
	logic [SNB_W-1:0]   n_snb;
	logic [PSIZE_W-1:0] n_psize;
	logic [ETICK_W-1:0] n_bcnt;
	logic [DATA_W-1:0]  n_rd;
	logic [STATUS_W-1:0] n_st;
	op_kind_t           n_kind;
	logic               bsy, addr_ok;
	logic [FW-1:0]      er_base, er_sum, er_end;
	logic [FW:0]        sweep_next;
	logic               sweep_we;

	assign cfg_ready = 1'b1;
	assign read_data = rd_q;
	assign status    = st_q;
	assign busy_res  = (bcnt_q != '0);
	assign locked    = lock_q;

	assign bsy     = (bcnt_q != '0);
	assign addr_ok = ({1'b0, addr_q} < MEM_A);

	// Erase range of the selected sector, clipped to the implemented array.
	assign er_base = FW'(n_snb) * WPS_F;
	assign er_sum  = er_base + WPS_F;
	assign er_end  = (er_sum > MEM_F) ? MEM_F : er_sum;

	assign sweep_next      = {1'b0, sweep_addr_q} + (FW + 1)'(1);
	assign sweep_we        = cmd.sweep && (sweep_addr_q < sweep_end_q);
	assign stat.sweep_last = (sweep_next >= {1'b0, sweep_end_q});
	assign stat.kind       = n_kind;

	// Decode of one item against the current state.
	always_comb begin
		n_lock  = lock_q;
		n_key   = key_q;
		n_pg    = pg_q;
		n_ser   = ser_q;
		n_snb   = snb_q;
		n_psize = psize_q;
		n_bcnt  = bcnt_q;
		n_rd    = '0;
		n_st    = ST_OK;
		n_kind  = K_SIMPLE;
		unique case (act_q)
			ACT_TICK: begin
				if (bsy) begin
					n_bcnt = bcnt_q - ETICK_W'(1);
				end
			end
			ACT_REG_WR: begin
				if (sel_q == SEL_KEY) begin
					if (lock_q) begin
						if (!key_q && data_q == KEY_FIRST) begin
							n_key = 1'b1;
						end else if (key_q && data_q == KEY_SECOND) begin
							n_key  = 1'b0;
							n_lock = 1'b0;
						end else begin
							n_key = 1'b0;
							n_st  = ST_BADKEY;
						end
					end
				end else if (sel_q == SEL_CTRL) begin
					if (lock_q) begin
						n_st = ST_LOCKED;
					end else if (bsy) begin
						n_st = ST_BUSY;
					end else begin
						n_pg    = data_q[CR_PG];
						n_ser   = data_q[CR_SER];
						n_snb   = data_q[CR_SNB_LSB +: SNB_W];
						n_psize = data_q[CR_PSIZE_LSB +: PSIZE_W];
						if (data_q[CR_STRT]) begin
							if (n_ser && ({1'b0, n_snb} < NSEC_F)) begin
								n_kind = K_ERASE;
								n_bcnt = erase_ticks_q;
							end else begin
								n_st = ST_DISABLED;
							end
						end
						if (data_q[CR_LOCK]) begin
							n_lock = 1'b1;
							n_key  = 1'b0;
						end
					end
				end
			end
			ACT_REG_RD: begin
				if (sel_q == SEL_STATUS) begin
					n_rd[SR_BSY] = bsy;
				end else if (sel_q == SEL_CTRL) begin
					n_rd[CR_PG]                      = pg_q;
					n_rd[CR_SER]                     = ser_q;
					n_rd[CR_SNB_LSB +: SNB_W]        = snb_q;
					n_rd[CR_PSIZE_LSB +: PSIZE_W]    = psize_q;
					n_rd[CR_LOCK]                    = lock_q;
				end
			end
			ACT_ARR_WR: begin
				if (lock_q) begin
					n_st = ST_LOCKED;
				end else if (bsy) begin
					n_st = ST_BUSY;
				end else if (!pg_q || !addr_ok) begin
					n_st = ST_DISABLED;
				end else begin
					n_kind = K_PROG;
					n_bcnt = ETICK_W'(prog_ticks_q);
				end
			end
			ACT_ARR_RD: begin
				if (bsy) begin
					n_st = ST_BUSY;
				end else if (!addr_ok) begin
					n_st = ST_DISABLED;
				end else begin
					n_kind = K_READ;
				end
			end
			default: begin
			end
		endcase
	end

	// Input latch on transfer.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			sel_q  <= reg_select;
			addr_q <= word_address;
			data_q <= write_data;
		end
	end

	// Control and configuration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q        <= 1'b1;
			key_q         <= 1'b0;
			pg_q          <= 1'b0;
			ser_q         <= 1'b0;
			snb_q         <= '0;
			psize_q       <= '0;
			bcnt_q        <= '0;
			erase_ticks_q <= ETICK_W'(100);
			prog_ticks_q  <= PTICK_W'(2);
			kind_q        <= K_SIMPLE;
			sweep_addr_q  <= '0;
			sweep_end_q   <= MEM_F;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ERASE_TICKS:   erase_ticks_q <= cfg_data;
					CFG_PROGRAM_TICKS: prog_ticks_q  <= cfg_data[PTICK_W-1:0];
				endcase
			end
			if (cmd.exec) begin
				lock_q  <= n_lock;
				key_q   <= n_key;
				pg_q    <= n_pg;
				ser_q   <= n_ser;
				snb_q   <= n_snb;
				psize_q <= n_psize;
				bcnt_q  <= n_bcnt;
				kind_q  <= n_kind;
				if (n_kind == K_ERASE) begin
					sweep_addr_q <= er_base;
					sweep_end_q  <= er_end;
				end
			end else if (cmd.sweep) begin
				sweep_addr_q <= sweep_next[FW-1:0];
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_q <= n_rd;
			st_q <= n_st;
		end else if (cmd.fin && kind_q == K_READ) begin
			rd_q <= rdata_q;
		end
	end

	// Flash array: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (sweep_we) begin
			mem[sweep_addr_q[MAW-1:0]] <= '1;
		end else if (cmd.fin && kind_q == K_PROG) begin
			mem[addr_q[MAW-1:0]] <= rdata_q & data_q;
		end
		rdata_q <= mem[addr_q[MAW-1:0]];
	end

endmodule

// ===== test/flash_program_erase_controller_checker.sv =====
// Checker that predicts every bus access reply of the flash controller and compares it.
module flash_program_erase_controller_checker #(
	parameter int NUM_SECTORS      = 8,
	parameter int WORDS_PER_SECTOR = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic                            done,
	input  logic [fpec_pkg::ACTION_W-1:0]   action,
	input  logic [fpec_pkg::SEL_W-1:0]      reg_select,
	input  logic [fpec_pkg::WADDR_W-1:0]    word_address,
	input  logic [fpec_pkg::DATA_W-1:0]     write_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [fpec_pkg::ETICK_W-1:0]    cfg_data,
	input  logic [fpec_pkg::DATA_W-1:0]     read_data,
	input  logic                            busy_res,
	input  logic                            locked,
	input  logic [fpec_pkg::STATUS_W-1:0]   status,
	output int                              fail_count,
	output int                              pending_results
);
	timeunit 1ns;
	timeprecision 1ps;
	import fpec_pkg::*;

	localparam int ARRAY_WORDS = NUM_SECTORS * WORDS_PER_SECTOR;
	localparam int PRINT_CAP   = 200;

	// One reply of the controller, field by field.
	typedef struct packed {
		logic [DATA_W-1:0]   read_word;
		logic                busy_flag;
		logic                lock_flag;
		logic [STATUS_W-1:0] code;
	} bus_reply_t;

	// Predicted replies still waiting for their strobe.
	bus_reply_t replies_due[$];
	int reply_count;

	// Timing registers as written over the configuration channel.
	logic [ETICK_W-1:0] erase_len;
	logic [PTICK_W-1:0] prog_len;

	// Predicted controller state.
	logic               ctl_locked;
	logic               key_half;
	logic               pg_en;
	logic               ser_en;
	logic [SNB_W-1:0]   sector_sel;
	logic [PSIZE_W-1:0] psize_sel;
	logic [ETICK_W-1:0] busy_ticks;
	logic [DATA_W-1:0]  flash_words [ARRAY_WORDS];

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (fail_count < PRINT_CAP) begin
			$display("%0t ns: result %0d: %s is %0h, predicted %0h",
				$realtime, reply_count, what, got, want);
		end
		fail_count++;
	endtask

	// Applies one accepted bus access to the predicted state and forms its reply.
	task automatic apply_bus_access(input logic [ACTION_W-1:0] act,
			input logic [SEL_W-1:0] sel, input logic [WADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data, output bus_reply_t reply);
		logic [DATA_W-1:0]   word;
		logic [STATUS_W-1:0] code;
		int                  base;
		int                  i;
		word = '0;
		code = ST_OK;
		case (act)
			ACT_TICK: begin
				if (busy_ticks != 0) busy_ticks--;
			end
			ACT_REG_WR: begin
				if (sel == SEL_KEY) begin
					// The unlock sequence only matters while locked.
					if (ctl_locked) begin
						if (!key_half && data == KEY_FIRST) begin
							key_half = 1'b1;
						end else if (key_half && data == KEY_SECOND) begin
							key_half = 1'b0;
							ctl_locked = 1'b0;
						end else begin
							key_half = 1'b0;
							code = ST_BADKEY;
						end
					end
				end else if (sel == SEL_CTRL) begin
					if (ctl_locked) begin
						code = ST_LOCKED;
					end else if (busy_ticks != 0) begin
						code = ST_BUSY;
					end else begin
						pg_en = data[CR_PG];
						ser_en = data[CR_SER];
						sector_sel = data[CR_SNB_LSB +: SNB_W];
						psize_sel = data[CR_PSIZE_LSB +: PSIZE_W];
						// A start with sector erase wipes the whole sector at once.
						if (data[CR_STRT]) begin
							if (ser_en && int'(sector_sel) < NUM_SECTORS) begin
								base = int'(sector_sel) * WORDS_PER_SECTOR;
								for (i = 0; i < WORDS_PER_SECTOR; i++) begin
									flash_words[base + i] = '1;
								end
								busy_ticks = erase_len;
							end else begin
								code = ST_DISABLED;
							end
						end
						if (data[CR_LOCK]) begin
							ctl_locked = 1'b1;
							key_half = 1'b0;
						end
					end
				end
			end
			ACT_REG_RD: begin
				if (sel == SEL_STATUS) begin
					word[SR_BSY] = (busy_ticks != 0);
				end else if (sel == SEL_CTRL) begin
					word[CR_PG] = pg_en;
					word[CR_SER] = ser_en;
					word[CR_SNB_LSB +: SNB_W] = sector_sel;
					word[CR_PSIZE_LSB +: PSIZE_W] = psize_sel;
					word[CR_LOCK] = ctl_locked;
				end
			end
			ACT_ARR_WR: begin
				// Programming can only clear bits.
				if (ctl_locked) begin
					code = ST_LOCKED;
				end else if (busy_ticks != 0) begin
					code = ST_BUSY;
				end else if (!pg_en || int'(addr) >= ARRAY_WORDS) begin
					code = ST_DISABLED;
				end else begin
					flash_words[addr] = flash_words[addr] & data;
					busy_ticks = ETICK_W'(prog_len);
				end
			end
			ACT_ARR_RD: begin
				if (busy_ticks != 0) begin
					code = ST_BUSY;
				end else if (int'(addr) >= ARRAY_WORDS) begin
					code = ST_DISABLED;
				end else begin
					word = flash_words[addr];
				end
			end
			default: begin
			end
		endcase
		reply = '{word, (busy_ticks != 0), ctl_locked, code};
	endtask

	// Watches configuration transfers, result strobes and accepted items.
	always @(posedge clk or negedge arst_n) begin : watch
		bus_reply_t seen;
		bus_reply_t due;
		int         i;
		if (!arst_n) begin
			erase_len = 16'd100;
			prog_len = 8'd2;
			ctl_locked = 1'b1;
			key_half = 1'b0;
			pg_en = 1'b0;
			ser_en = 1'b0;
			sector_sel = '0;
			psize_sel = '0;
			busy_ticks = '0;
			for (i = 0; i < ARRAY_WORDS; i++) begin
				flash_words[i] = '1;
			end
			replies_due.delete();
		end else begin
			// Timing register writes.
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ERASE_TICKS) erase_len = cfg_data;
				else prog_len = cfg_data[PTICK_W-1:0];
			end
			// A strobed result is matched against the oldest prediction.
			if (done) begin
				seen = '{read_data, busy_res, locked, status};
				if (replies_due.size() == 0) begin
					report_mismatch("unexpected result, read_data", seen.read_word, '0);
				end else begin
					due = replies_due.pop_front();
					if (seen.read_word !== due.read_word) begin
						report_mismatch("read_data", seen.read_word, due.read_word);
					end
					if (seen.busy_flag !== due.busy_flag) begin
						report_mismatch("busy_res", seen.busy_flag, due.busy_flag);
					end
					if (seen.lock_flag !== due.lock_flag) begin
						report_mismatch("locked", seen.lock_flag, due.lock_flag);
					end
					if (seen.code !== due.code) begin
						report_mismatch("status", seen.code, due.code);
					end
				end
				reply_count++;
			end
			// Each accepted item is predicted at the edge of its transfer.
			if (start && !busy) begin
				apply_bus_access(action, reg_select, word_address, write_data, due);
				replies_due.push_back(due);
			end
		end
		pending_results <= replies_due.size();
	end

endmodule

// ===== test/flash_program_erase_controller_test.sv =====
// Testbench top: drives bus accesses and timing writes into the flash controller.
module flash_program_erase_controller_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fpec_pkg::*;

	localparam int NUM_SECTORS      = 8;
	localparam int WORDS_PER_SECTOR = 64;
	localparam int CYCLE_LIMIT      = 1_200_000;
	localparam int SETTLE_CYCLES    = 80;
	localparam int PHASE_ITEMS      = 55;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  done;
	logic [ACTION_W-1:0]   action;
	logic [SEL_W-1:0]      reg_select;
	logic [WADDR_W-1:0]    word_address;
	logic [DATA_W-1:0]     write_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [ETICK_W-1:0]    cfg_data;
	logic [DATA_W-1:0]     read_data;
	logic                  busy_res;
	logic                  locked;
	logic [STATUS_W-1:0]   status;
	int                    fail_count;
	int                    pending_results;

	int                    cycle_count = 0;
	int                    burst_left = 0;
	int                    items_sent = 0;
	logic [ETICK_W-1:0]    erase_len = 16'd100;
	logic [PTICK_W-1:0]    prog_len = 8'd2;

	flash_program_erase_controller #(
		.NUM_SECTORS(NUM_SECTORS),
		.WORDS_PER_SECTOR(WORDS_PER_SECTOR)
	) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.action(action), .reg_select(reg_select), .word_address(word_address),
		.write_data(write_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .read_data(read_data),
		.busy_res(busy_res), .locked(locked), .status(status)
	);

	flash_program_erase_controller_checker #(
		.NUM_SECTORS(NUM_SECTORS),
		.WORDS_PER_SECTOR(WORDS_PER_SECTOR)
	) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.action(action), .reg_select(reg_select), .word_address(word_address),
		.write_data(write_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .read_data(read_data),
		.busy_res(busy_res), .locked(locked), .status(status),
		.fail_count(fail_count), .pending_results(pending_results)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Sends one item in bursts with random gaps and waits for its transfer.
	task automatic issue(input logic [ACTION_W-1:0] act, input logic [SEL_W-1:0] sel,
			input logic [WADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		action <= act;
		reg_select <= sel;
		word_address <= addr;
		write_data <= data;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic reg_write(input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] data);
		issue(ACT_REG_WR, sel, WADDR_W'($urandom), data);
	endtask

	task automatic reg_read(input logic [SEL_W-1:0] sel);
		issue(ACT_REG_RD, sel, WADDR_W'($urandom), $urandom);
	endtask

	task automatic arr_write(input logic [WADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		issue(ACT_ARR_WR, SEL_W'($urandom), addr, data);
	endtask

	task automatic arr_read(input logic [WADDR_W-1:0] addr);
		issue(ACT_ARR_RD, SEL_W'($urandom), addr, $urandom);
	endtask

	task automatic run_ticks(input int count);
		repeat (count) issue(ACT_TICK, SEL_W'($urandom), WADDR_W'($urandom), $urandom);
	endtask

	task automatic unlock();
		reg_write(SEL_KEY, KEY_FIRST);
		reg_write(SEL_KEY, KEY_SECOND);
	endtask

	// Control word with the named fields set and random content elsewhere.
	function automatic logic [DATA_W-1:0] ctrl_word(input logic pg, input logic ser,
			input logic [SNB_W-1:0] snb, input logic strt, input logic lck);
		logic [DATA_W-1:0] word;
		word = $urandom;
		word[CR_PG] = pg;
		word[CR_SER] = ser;
		word[CR_SNB_LSB +: SNB_W] = snb;
		word[CR_STRT] = strt;
		word[CR_LOCK] = lck;
		return word;
	endfunction

	// Stops sending until every predicted result has arrived and the block is quiet.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both timing registers while the block is idle.
	task automatic set_timing(input logic [ETICK_W-1:0] erase_val,
			input logic [PTICK_W-1:0] prog_val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ERASE_TICKS;
		cfg_data <= erase_val;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_PROGRAM_TICKS;
		cfg_data <= ETICK_W'(prog_val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		erase_len = erase_val;
		prog_len = prog_val;
	endtask

	// Mostly well-formed program and erase sequences, with register traffic and noise.
	task automatic random_phase(input int count);
		int                 goal;
		int                 pick;
		int                 n;
		int                 i;
		logic [WADDR_W-1:0] base;
		logic [WADDR_W-1:0] addr;
		logic [SNB_W-1:0]   snb;
		logic [DATA_W-1:0]  data;
		goal = items_sent + count;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				// Program words of one small neighborhood and read them back.
				unlock();
				reg_write(SEL_CTRL, ctrl_word(1'b1, 1'($urandom), SNB_W'($urandom), 1'b0, 1'b0));
				base = WADDR_W'($urandom_range(0, 511)) & ~WADDR_W'(7);
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) begin
					addr = base | WADDR_W'($urandom_range(0, 7));
					arr_write(addr, $urandom | $urandom);
					if ($urandom_range(0, 3) == 0) arr_read(addr);
					run_ticks(int'(prog_len) - 1 + int'($urandom_range(0, 2)));
					arr_read(addr);
				end
				if ($urandom_range(0, 2) == 0) reg_write(SEL_CTRL, ctrl_word(1'b0, 1'b0, '0, 1'b0, 1'b1));
			end else if (pick < 55) begin
				// Erase a sector, sometimes after dirtying a word in it.
				unlock();
				if ($urandom_range(0, 7) == 0) begin
					snb = SNB_W'($urandom_range(NUM_SECTORS, 15));
					addr = WADDR_W'($urandom_range(0, 511));
				end else begin
					snb = SNB_W'($urandom_range(0, NUM_SECTORS - 1));
					addr = WADDR_W'(int'(snb) * WORDS_PER_SECTOR
						+ int'($urandom_range(0, WORDS_PER_SECTOR - 1)));
				end
				if ($urandom_range(0, 1) == 0) begin
					reg_write(SEL_CTRL, ctrl_word(1'b1, 1'b0, snb, 1'b0, 1'b0));
					arr_write(addr, $urandom);
					run_ticks(int'(prog_len));
				end
				reg_write(SEL_CTRL, ctrl_word(1'($urandom), 1'b1, snb, 1'b1, 1'b0));
				if ($urandom_range(0, 2) == 0) reg_write(SEL_CTRL, $urandom);
				run_ticks(int'(erase_len) - 1 + int'($urandom_range(0, 2)));
				reg_read(SEL_STATUS);
				arr_read(addr);
			end else if (pick < 70) begin
				// Register reads, sometimes followed by a relock.
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) reg_read(SEL_W'($urandom));
				if ($urandom_range(0, 1) == 0) reg_write(SEL_CTRL, ctrl_word(1'($urandom),
					1'($urandom), SNB_W'($urandom), 1'($urandom), 1'b1));
			end else begin
				// Unconstrained items, key words among the data.
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(0, 3))
						0: data = KEY_FIRST;
						1: data = KEY_SECOND;
						default: data = $urandom;
					endcase
					issue(ACTION_W'($urandom_range(0, 7)), SEL_W'($urandom),
						WADDR_W'($urandom), data);
				end
			end
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_TICK;
		reg_select <= SEL_KEY;
		word_address <= '0;
		write_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ERASE_TICKS;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reads straight after reset: erased array, locked control.
		reg_read(SEL_STATUS);
		reg_read(SEL_CTRL);
		reg_read(SEL_KEY);
		reg_read(SEL_W'(3));
		arr_read('0);
		arr_read('1);

		// Writes rejected while locked, then the key sequence with wrong words.
		reg_write(SEL_CTRL, ctrl_word(1'b1, 1'b0, '0, 1'b0, 1'b0));
		arr_write('0, '0);
		reg_write(SEL_KEY, KEY_SECOND);
		reg_write(SEL_KEY, KEY_FIRST);
		reg_write(SEL_KEY, KEY_FIRST);
		unlock();
		reg_write(SEL_KEY, $urandom);
		reg_write(SEL_STATUS, '1);
		reg_write(SEL_W'(3), '1);

		// Program disabled, then one program and accesses while it is busy.
		reg_write(SEL_CTRL, ctrl_word(1'b0, 1'b0, '0, 1'b0, 1'b0));
		arr_write('1, '0);
		reg_write(SEL_CTRL, ctrl_word(1'b1, 1'b0, '0, 1'b0, 1'b0));
		arr_write('1, '0);
		arr_write('1, '0);
		arr_read('1);
		reg_write(SEL_CTRL, '1);
		run_ticks(int'(prog_len));
		arr_read('1);

		// Erase starts that must fail, then a real erase of the last sector.
		reg_write(SEL_CTRL, ctrl_word(1'b0, 1'b1, SNB_W'(15), 1'b1, 1'b0));
		reg_write(SEL_CTRL, ctrl_word(1'b0, 1'b0, SNB_W'(NUM_SECTORS - 1), 1'b1, 1'b0));
		reg_write(SEL_CTRL, ctrl_word(1'b0, 1'b1, SNB_W'(NUM_SECTORS - 1), 1'b1, 1'b0));
		run_ticks(int'(erase_len));
		arr_read('1);

		// Unknown actions and relocking.
		issue(ACTION_W'(5), SEL_W'($urandom), WADDR_W'($urandom), $urandom);
		issue(ACTION_W'(6), SEL_W'($urandom), WADDR_W'($urandom), $urandom);
		issue(ACTION_W'(7), SEL_W'($urandom), WADDR_W'($urandom), $urandom);
		reg_write(SEL_CTRL, ctrl_word(1'b0, 1'b0, '0, 1'b0, 1'b1));
		reg_read(SEL_CTRL);

		// Shortest timing.
		set_timing(16'd1, 8'd1);
		random_phase(PHASE_ITEMS);

		// Several random timings.
		repeat (4) begin
			set_timing(ETICK_W'($urandom_range(2, 40)), PTICK_W'($urandom_range(1, 8)));
			random_phase(PHASE_ITEMS);
		end

		// Drain any leftover busy time and restart the key sequence.
		reg_write(SEL_KEY, '0);
		run_ticks(40);

		// Longest timing: a program runs out completely, an erase is left running.
		set_timing(16'hFFFF, 8'hFF);
		unlock();
		reg_write(SEL_CTRL, ctrl_word(1'b1, 1'b0, '0, 1'b0, 1'b0));
		arr_write('0, $urandom);
		run_ticks(int'(prog_len) - 1);
		arr_read('0);
		run_ticks(1);
		arr_read('0);
		reg_write(SEL_CTRL, ctrl_word(1'b0, 1'b1, '0, 1'b1, 1'b0));
		reg_read(SEL_STATUS);
		run_ticks(3);
		reg_read(SEL_STATUS);
		arr_read('0);
		reg_write(SEL_CTRL, ctrl_word(1'b0, 1'b0, '0, 1'b0, 1'b1));

		settle();
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
